FILE: src/bbpa_pkg.sv
// Shared types and constants of the bitmap block pool allocator.
package bbpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int BLOCK_W    = 17;
	localparam int NBLK_W     = 7;
	localparam int PAGE_W     = 21;
	localparam int LIMIT_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_CNT_W  = $clog2(PAGE_W + 1);

	localparam logic [7:0]  MAP_FILL_BYTE = 8'hff;
	localparam logic [63:0] MAP_FILL      = {8{MAP_FILL_BYTE}};

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_PAGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT     = 3'd4;

	localparam logic [BLOCK_W-1:0] RST_BLOCK_BYTES    = 17'd64;
	localparam logic [NBLK_W-1:0]  RST_BLOCKS_IN_PAGE = 7'd64;
	localparam logic [PAGE_W-1:0]  RST_PAGE_BYTES     = 21'd4096;
	localparam logic [ADDR_W-1:0]  RST_POOL_BASE      = 32'd0;
	localparam logic [LIMIT_W-1:0] RST_PAGE_LIMIT     = 5'd16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_PAGE      = 2'd1,
		ST_BAD_ADDR     = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic               start;
		logic [PAGE_W-1:0]  dividend;
		logic [BLOCK_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PAGE_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: src/bbpa_req_if.sv
// Request channel: operation and address to free.
interface bbpa_req_if import bbpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ADDR_W-1:0] free_addr;

	modport source (output valid, output op, output free_addr, input ready);
	modport sink (input valid, input op, input free_addr, output ready);
endinterface

FILE: src/bbpa_rsp_if.sv
// Response channel: status and allocated block address.
interface bbpa_rsp_if import bbpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] block_addr;

	modport source (output valid, output status, output block_addr, input ready);
	modport sink (input valid, input status, input block_addr, output ready);
endinterface

FILE: src/bbpa_cfg_if.sv
// Configuration write channel: register index and write data.
interface bbpa_cfg_if import bbpa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/bbpa_map_ram.sv
// Free bitmap memory: one write port, one registered read port that holds its data.
module bbpa_map_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: src/bbpa_div.sv
// Restoring divider for page offset by block size, one quotient bit per cycle.
module bbpa_div import bbpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BLOCK_W-1:0]   rem_q;
	logic [PAGE_W-1:0]    quo_q;
	logic [BLOCK_W-1:0]   dvs_q;
	logic [BLOCK_W:0]     trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[PAGE_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && cnt_q == DIV_CNT_W'(1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(PAGE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? BLOCK_W'(trial - {1'b0, dvs_q}) : trial[BLOCK_W-1:0];
			quo_q <= {quo_q[PAGE_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

FILE: src/bitmap_block_pool_allocator.sv
// Bitmap block pool allocator: top level with request sequencer and shared multiplier.
//
// One request at a time. An allocate scans the present pages, with one memory read and
// one bitmap check each, and brings in a new page when none has a free block; a failed
// allocate scans every present page without finding room; a free tests the pages and,
// on a hit, waits on the restoring divider that turns the page offset into a block index.
// The bitmap memory has one write port and one registered read port, and the one
// registered multiplier is shared by the slot base and the block offset. A finished
// result sits in an output register, and the next request is taken while it waits.
module bitmap_block_pool_allocator import bbpa_pkg::*; #(
	parameter int MAX_PAGES  = 16,
	parameter int MAX_BLOCKS = 64
) (
	input logic         clk,
	input logic         arst_n,
	bbpa_req_if.sink    req,
	bbpa_rsp_if.source  rsp,
	bbpa_cfg_if.sink    cfg
);
	localparam int PW   = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
	localparam int PCW  = $clog2(MAX_PAGES + 1);
	localparam int LW   = PCW > LIMIT_W ? PCW : LIMIT_W;
	localparam int IW   = MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1;
	localparam int MB   = MAX_BLOCKS;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_ARD   = 12'b000000000010,
		S_ACHK  = 12'b000000000100,
		S_NEWPG = 12'b000000001000,
		S_MP    = 12'b000000010000,
		S_MI    = 12'b000000100000,
		S_ADD   = 12'b000001000000,
		S_FMP   = 12'b000010000000,
		S_FBASE = 12'b000100000000,
		S_FCMP  = 12'b001000000000,
		S_FDIV  = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [BLOCK_W-1:0] bb_q;
	logic [NBLK_W-1:0]  nbp_q;
	logic [PAGE_W-1:0]  pgb_q;
	logic [ADDR_W-1:0]  base_q;
	logic [LIMIT_W-1:0] lim_q;

	logic [PCW-1:0]    pp_q;
	logic [PW-1:0]     p_q;
	logic [IW-1:0]     idx_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [ADDR_W-1:0] cur_base_q;
	logic [ADDR_W-1:0] acc_q;
	logic [ADDR_W-1:0] prod_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [ADDR_W-1:0] rsp_addr_q;

	logic [BLOCK_W-1:0] ebb;
	logic [PAGE_W-1:0]  epb;
	logic [NBLK_W-1:0]  enb;
	logic [LW-1:0]      elim;
	logic [LW-1:0]      lim_ext;
	logic [MB-1:0]      vm;
	logic [MB-1:0]      masked;
	logic [MB-1:0]      lowbit;
	logic [IW-1:0]      lo_idx;
	logic [ADDR_W-1:0]  mul_a;
	logic [ADDR_W-1:0]  mul_b;
	logic [ADDR_W-1:0]  off;
	logic               off_hit;
	logic [IW-1:0]      qi;
	logic               q_bad;
	logic               out_free;

	logic          map_we;
	logic [PW-1:0] map_waddr;
	logic [MB-1:0] map_wdata;
	logic          map_re;
	logic [MB-1:0] map_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	bbpa_map_ram #(
		.DEPTH(MAX_PAGES),
		.WIDTH(MB)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (map_re),
		.raddr(p_q),
		.rdata(map_rdata)
	);

	bbpa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign ebb     = (bb_q == '0) ? BLOCK_W'(1) : bb_q;
	assign epb     = (pgb_q == '0) ? PAGE_W'(1) : pgb_q;
	assign enb     = (nbp_q == '0) ? NBLK_W'(1) :
		(nbp_q > NBLK_W'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS) : nbp_q;
	assign lim_ext = LW'(lim_q);
	assign elim    = (lim_ext > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : lim_ext;

	always_comb begin
		for (int i = 0; i < MB; i++) begin
			vm[i] = NBLK_W'(i) < enb;
		end
	end

	assign masked = map_rdata & vm;
	assign lowbit = masked & (~masked + MB'(1));

	always_comb begin
		lo_idx = '0;
		for (int i = 0; i < MB; i++) begin
			if (lowbit[i]) begin
				lo_idx = lo_idx | IW'(i);
			end
		end
	end

	assign off     = faddr_q - cur_base_q;
	assign off_hit = off < ADDR_W'(epb);
	assign qi      = div_rsp.quotient[IW-1:0];
	assign q_bad   = div_rsp.quotient >= PAGE_W'(enb);

	assign mul_a = (state_q == S_MI) ? ADDR_W'(ebb) : ADDR_W'(epb);
	assign mul_b = (state_q == S_MI) ? ADDR_W'(idx_q) : ADDR_W'(p_q);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		map_we           = 1'b0;
		map_waddr        = p_q;
		map_wdata        = map_rdata;
		map_re           = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = off[PAGE_W-1:0];
		div_req.divisor  = ebb;
		case (state_q)
			S_ARD: begin
				map_re = 1'b1;
			end
			S_ACHK: begin
				map_we    = masked != '0;
				map_wdata = map_rdata & ~lowbit;
			end
			S_NEWPG: begin
				map_we    = LW'(pp_q) < elim;
				map_waddr = PW'(pp_q);
				map_wdata = MAP_FILL[MB-1:0] & ~MB'(1);
			end
			S_FCMP: begin
				map_re        = off_hit;
				div_req.start = off_hit;
			end
			S_FDIV: begin
				map_we    = div_rsp.done && !q_bad && !map_rdata[qi];
				map_wdata = map_rdata | (MB'(1) << qi);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q   <= RST_BLOCK_BYTES;
			nbp_q  <= RST_BLOCKS_IN_PAGE;
			pgb_q  <= RST_PAGE_BYTES;
			base_q <= RST_POOL_BASE;
			lim_q  <= RST_PAGE_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BLOCK_BYTES:    bb_q   <= cfg.data[BLOCK_W-1:0];
				CFG_BLOCKS_IN_PAGE: nbp_q  <= cfg.data[NBLK_W-1:0];
				CFG_PAGE_BYTES:     pgb_q  <= cfg.data[PAGE_W-1:0];
				CFG_POOL_BASE:      base_q <= cfg.data[ADDR_W-1:0];
				CFG_PAGE_LIMIT:     lim_q  <= cfg.data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.op == OP_ALLOC) begin
							state_q <= (pp_q == '0) ? S_NEWPG : S_ARD;
						end else begin
							state_q <= (pp_q == '0) ? S_DONE : S_FMP;
						end
					end
				end
				S_ARD: state_q <= S_ACHK;
				S_ACHK: begin
					if (masked != '0) begin
						state_q <= S_MP;
					end else begin
						state_q <= (p_q == '0) ? S_NEWPG : S_ARD;
					end
				end
				S_NEWPG: begin
					if (LW'(pp_q) < elim) begin
						pp_q    <= pp_q + 1'b1;
						state_q <= S_MP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MP:    state_q <= S_MI;
				S_MI:    state_q <= S_ADD;
				S_ADD:   state_q <= S_DONE;
				S_FMP:   state_q <= S_FBASE;
				S_FBASE: state_q <= S_FCMP;
				S_FCMP: begin
					if (off_hit) begin
						state_q <= S_FDIV;
					end else if (p_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_FDIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				faddr_q      <= req.free_addr;
				p_q          <= PW'(pp_q - 1'b1);
				res_status_q <= ST_BAD_ADDR;
				res_addr_q   <= '0;
			end
			S_ACHK: begin
				idx_q <= lo_idx;
				if (masked == '0) begin
					p_q <= p_q - 1'b1;
				end
			end
			S_NEWPG: begin
				p_q          <= PW'(pp_q);
				idx_q        <= '0;
				res_status_q <= ST_NO_PAGE;
			end
			S_MI: begin
				acc_q <= base_q + prod_q;
			end
			S_ADD: begin
				res_addr_q   <= acc_q + prod_q;
				res_status_q <= ST_OK;
			end
			S_FBASE: begin
				cur_base_q <= base_q + prod_q;
			end
			S_FCMP: begin
				if (!off_hit) begin
					p_q        <= p_q - 1'b1;
					cur_base_q <= cur_base_q - ADDR_W'(epb);
				end
			end
			S_FDIV: begin
				if (div_rsp.done) begin
					if (q_bad) begin
						res_status_q <= ST_BAD_ADDR;
					end else if (map_rdata[qi]) begin
						res_status_q <= ST_ALREADY_FREE;
					end else begin
						res_status_q <= ST_OK;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					rsp_status_q <= res_status_q;
					rsp_addr_q   <= res_addr_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready      = state_q == S_IDLE;
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.block_addr = rsp_addr_q;

	a_pages_step: assert property (@(posedge clk) disable iff (!arst_n)
		pp_q != $past(pp_q) |-> pp_q == $past(pp_q) + 1'b1)
		else $error("page count moved by other than one");

	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pp_q != $past(pp_q) |-> $past(state_q) == S_NEWPG)
		else $error("page brought in outside page bring-up");

	a_map_write: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |-> state_q == S_ACHK || state_q == S_NEWPG || state_q == S_FDIV)
		else $error("bitmap written outside an update step");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && rsp_valid_q && !rsp.ready |=> state_q == S_DONE)
		else $error("result left while output register was occupied");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> state_q == S_FDIV)
		else $error("divider started without waiting for it");
endmodule

FILE: verif/bitmap_block_pool_allocator_tb.sv
// Self-checking testbench for the bitmap block pool allocator: shadow pool, directed and random traffic.
`timescale 1ns / 1ps

module bitmap_block_pool_allocator_tb;
	import bbpa_pkg::*;

	localparam int POOL_PAGES    = 16;
	localparam int POOL_BLOCKS   = 64;
	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 1560;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 48;
	localparam int REPORT_CAP    = 200;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] block_addr;
	} pool_reply_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bbpa_req_if req_bus ();
	bbpa_rsp_if rsp_bus ();
	bbpa_cfg_if cfg_bus ();

	bitmap_block_pool_allocator #(
		.MAX_PAGES  (POOL_PAGES),
		.MAX_BLOCKS (POOL_BLOCKS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// shadow copy of the registers and the pool
	logic [BLOCK_W-1:0] sh_block_bytes;
	logic [NBLK_W-1:0]  sh_blocks;
	logic [PAGE_W-1:0]  sh_page_bytes;
	logic [ADDR_W-1:0]  sh_pool_base;
	logic [LIMIT_W-1:0] sh_page_limit;
	logic [63:0]        sh_map [POOL_PAGES];
	int                 sh_pages;

	pool_reply_t awaited_replies [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          hold_cycles    = 0;
	bit          steady_traffic = 1'b0;

	function automatic void shadow_reset();
		int p;
		sh_block_bytes = RST_BLOCK_BYTES;
		sh_blocks      = RST_BLOCKS_IN_PAGE;
		sh_page_bytes  = RST_PAGE_BYTES;
		sh_pool_base   = RST_POOL_BASE;
		sh_page_limit  = RST_PAGE_LIMIT;
		for (p = 0; p < POOL_PAGES; p++)
			sh_map[p] = MAP_FILL;
		sh_pages = 0;
	endfunction

	function automatic void shadow_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		CFG_BLOCK_BYTES:    sh_block_bytes = data[BLOCK_W-1:0];
		CFG_BLOCKS_IN_PAGE: sh_blocks      = data[NBLK_W-1:0];
		CFG_PAGE_BYTES:     sh_page_bytes  = data[PAGE_W-1:0];
		CFG_POOL_BASE:      sh_pool_base   = data[ADDR_W-1:0];
		CFG_PAGE_LIMIT:     sh_page_limit  = data[LIMIT_W-1:0];
		default: ;
		endcase
	endfunction

	function automatic int unsigned block_size();
		return (sh_block_bytes == '0) ? 1 : int'(sh_block_bytes);
	endfunction

	function automatic int unsigned slot_len();
		return (sh_page_bytes == '0) ? 1 : int'(sh_page_bytes);
	endfunction

	function automatic int unsigned usable_blocks();
		int unsigned n;
		n = sh_blocks;
		if (n == 0)
			n = 1;
		if (n > POOL_BLOCKS)
			n = POOL_BLOCKS;
		return n;
	endfunction

	function automatic int unsigned page_cap();
		return (sh_page_limit > POOL_PAGES) ? POOL_PAGES : int'(sh_page_limit);
	endfunction

	function automatic logic [63:0] usable_bits();
		int unsigned n;
		n = usable_blocks();
		return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input int unsigned p);
		logic [63:0] a;
		a = 64'(sh_pool_base) + 64'(p) * 64'(slot_len());
		return a[ADDR_W-1:0];
	endfunction

	function automatic pool_reply_t predict_alloc();
		pool_reply_t r;
		logic [63:0] avail;
		int unsigned idx;
		int p;
		r.status     = ST_OK;
		r.block_addr = '0;
		for (p = sh_pages - 1; p >= 0; p--) begin
			avail = sh_map[p] & usable_bits();
			if (avail != '0) begin
				idx = 0;
				while (!avail[idx])
					idx++;
				sh_map[p][idx] = 1'b0;
				r.block_addr = slot_addr(p) + ADDR_W'(idx * block_size());
				return r;
			end
		end
		if (sh_pages >= page_cap() || sh_pages >= POOL_PAGES) begin
			r.status = ST_NO_PAGE;
			return r;
		end
		sh_map[sh_pages] = MAP_FILL & ~64'd1;
		r.block_addr = slot_addr(sh_pages);
		sh_pages++;
		return r;
	endfunction

	function automatic pool_reply_t predict_free(input logic [ADDR_W-1:0] addr);
		pool_reply_t r;
		logic [ADDR_W-1:0] offset;
		int unsigned idx;
		int p;
		r.status     = ST_BAD_ADDR;
		r.block_addr = '0;
		for (p = sh_pages - 1; p >= 0; p--) begin
			offset = addr - slot_addr(p);
			if (offset < slot_len()) begin
				idx = offset / block_size();
				if (idx >= usable_blocks()) begin
					r.status = ST_BAD_ADDR;
				end else if (sh_map[p][idx]) begin
					r.status = ST_ALREADY_FREE;
				end else begin
					sh_map[p][idx] = 1'b1;
					r.status = ST_OK;
				end
				return r;
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_traffic)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void report_mismatch(input string what, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (mismatch_count < REPORT_CAP)
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
		mismatch_count++;
	endfunction

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_bus.ready <= 1'b0;
			hold_cycles--;
		end else begin
			rsp_bus.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				hold_cycles = pick_gap();
		end
	end

	always @(posedge clk) begin : check_replies
		pool_reply_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (awaited_replies.size() == 0) begin
				report_mismatch("unexpected beat, status/addr", '0,
					{rsp_bus.status, rsp_bus.block_addr[ADDR_W-3:0]});
			end else begin
				want = awaited_replies.pop_front();
				if (rsp_bus.status !== want.status)
					report_mismatch("status", ADDR_W'(want.status), ADDR_W'(rsp_bus.status));
				if (rsp_bus.block_addr !== want.block_addr)
					report_mismatch("block_addr", want.block_addr, rsp_bus.block_addr);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d replies outstanding", $time, awaited_replies.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		shadow_config(idx, data);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	// set unused upper data bits now and then
	task automatic write_field(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value, input int width);
		logic [CFG_DATA_W-1:0] data;
		data = value;
		if (width < CFG_DATA_W && $urandom_range(0, 2) == 0)
			data |= $urandom() << width;
		write_register(idx, data);
	endtask

	task automatic issue_request(input logic op, input logic [ADDR_W-1:0] addr,
			output pool_reply_t reply);
		int gap;
		req_bus.valid     <= 1'b1;
		req_bus.op        <= op;
		req_bus.free_addr <= addr;
		do @(posedge clk); while (!req_bus.ready);
		if (op == OP_ALLOC)
			reply = predict_alloc();
		else
			reply = predict_free(addr);
		awaited_replies.push_back(reply);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_pool();
		req_bus.valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure_pool(input int unsigned bsize, input int unsigned blocks,
			input int unsigned psize, input logic [ADDR_W-1:0] base, input int unsigned limit);
		drain_pool();
		write_field(CFG_BLOCK_BYTES, bsize, BLOCK_W);
		write_field(CFG_BLOCKS_IN_PAGE, blocks, NBLK_W);
		write_field(CFG_PAGE_BYTES, psize, PAGE_W);
		write_field(CFG_POOL_BASE, base, ADDR_W);
		write_field(CFG_PAGE_LIMIT, limit, LIMIT_W);
	endtask

	task automatic run_traffic(input int n, input int alloc_weight);
		logic [ADDR_W-1:0] held [$];
		logic [ADDR_W-1:0] released [$];
		logic [ADDR_W-1:0] addr;
		logic              op;
		pool_reply_t       reply;
		int                i, q, b, r, pick;
		int unsigned       span;
		for (q = 0; q < sh_pages; q++)
			for (b = 0; b < usable_blocks(); b++)
				if (!sh_map[q][b])
					held.push_back(slot_addr(q) + ADDR_W'(b * block_size()));
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 199) == 0)
				drain_pool();
			r    = $urandom_range(0, 99);
			op   = OP_FREE;
			addr = $urandom();
			if (r < alloc_weight || (r < alloc_weight + 30 && held.size() == 0)) begin
				op = OP_ALLOC;
			end else if (r < alloc_weight + 30) begin
				pick = $urandom_range(0, held.size() - 1);
				addr = held[pick];
				held.delete(pick);
				if ($urandom_range(0, 3) == 0)
					addr += $urandom_range(0, block_size() - 1);
			end else begin
				case ($urandom_range(0, 4))
				0: if (released.size() != 0)
					addr = released[$urandom_range(0, released.size() - 1)];
				1: begin
					span = usable_blocks() * block_size();
					if (sh_pages > 0 && span < slot_len())
						addr = slot_addr($urandom_range(0, sh_pages - 1))
							+ ADDR_W'($urandom_range(span, slot_len() - 1));
				end
				2: addr = slot_addr(sh_pages) + ADDR_W'($urandom_range(0, 3));
				3: addr = sh_pool_base - ADDR_W'($urandom_range(1, 4));
				default: op = ($urandom_range(0, 1) != 0);
				endcase
			end
			issue_request(op, addr, reply);
			if (op == OP_ALLOC && reply.status == ST_OK)
				held.push_back(reply.block_addr);
			if (op == OP_FREE && reply.status == ST_OK) begin
				released.push_back(addr);
				if (released.size() > 32)
					void'(released.pop_front());
			end
		end
	endtask

	task automatic test_reset_defaults();
		pool_reply_t reply;
		issue_request(OP_ALLOC, '0, reply);
		issue_request(OP_ALLOC, '0, reply);
		issue_request(OP_FREE, ADDR_W'(RST_BLOCK_BYTES), reply);
		issue_request(OP_FREE, ADDR_W'(RST_BLOCK_BYTES), reply);
		issue_request(OP_FREE, ADDR_W'(5), reply);
		issue_request(OP_FREE, '1, reply);
		issue_request(OP_FREE, ADDR_W'(RST_PAGE_BYTES), reply);
	endtask

	task automatic test_wrap_and_slack();
		pool_reply_t reply;
		configure_pool(100, 3, 350, 32'hffff_ff00, 1);
		repeat (4) issue_request(OP_ALLOC, $urandom(), reply);
		issue_request(OP_FREE, slot_addr(0) + 310, reply);
		issue_request(OP_FREE, slot_addr(0) + 207, reply);
		issue_request(OP_FREE, slot_addr(0) + 350, reply);
	endtask

	task automatic test_degenerate_registers();
		pool_reply_t reply;
		int k;
		configure_pool(0, 0, 0, sh_pool_base, 31);
		for (k = 1; k <= 3; k++)
			write_register(CFG_IDX_W'(CFG_PAGE_LIMIT + k), '1);
		issue_request(OP_ALLOC, '0, reply);
		issue_request(OP_FREE, slot_addr(1), reply);
		issue_request(OP_FREE, slot_addr(1), reply);
		drain_pool();
		write_field(CFG_PAGE_LIMIT, 0, LIMIT_W);
		issue_request(OP_ALLOC, '0, reply);
		issue_request(OP_ALLOC, '0, reply);
		drain_pool();
		write_field(CFG_BLOCKS_IN_PAGE, 127, NBLK_W);
		issue_request(OP_FREE, slot_addr(0), reply);
	endtask

	task automatic test_extreme_sizes();
		configure_pool(65536, 16, 1048576, 32'hffff_ffff, 16);
		run_traffic(60, 50);
		configure_pool(17'h1ffff, 64, 21'h1fffff, '0, 31);
		run_traffic(60, 50);
	endtask

	task automatic test_random_pools();
		int          sent, len;
		int unsigned blocks, bsize, span, psize, limit;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			blocks = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 127);
			case ($urandom_range(0, 2))
			0: bsize = $urandom_range(1, 16);
			1: bsize = 1 << $urandom_range(0, 16);
			default: bsize = $urandom_range(0, 131071);
			endcase
			span = (blocks == 0 ? 1 : blocks) * (bsize == 0 ? 1 : bsize);
			if (span <= 21'h1fffff - bsize && $urandom_range(0, 9) != 0)
				psize = span + $urandom_range(0, bsize);
			else
				psize = $urandom_range(0, 21'h1fffff);
			limit = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 31);
			steady_traffic = 1'b0;
			configure_pool(bsize, blocks, psize, $urandom(), limit);
			if ($urandom_range(0, 4) == 0)
				write_register(CFG_IDX_W'(CFG_PAGE_LIMIT + $urandom_range(1, 3)), $urandom());
			steady_traffic = ($urandom_range(0, 3) == 0);
			len = $urandom_range(80, 160);
			if (len > RANDOM_ITEMS - sent)
				len = RANDOM_ITEMS - sent;
			run_traffic(len, $urandom_range(35, 60));
			sent += len;
		end
		steady_traffic = 1'b0;
	endtask

	initial begin
		req_bus.valid     = 1'b0;
		req_bus.op        = OP_ALLOC;
		req_bus.free_addr = '0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = CFG_BLOCK_BYTES;
		cfg_bus.data      = '0;
		rsp_bus.ready     = 1'b0;
		shadow_reset();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_wrap_and_slack();
		test_degenerate_registers();
		test_extreme_sizes();
		test_random_pools();
		drain_pool();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/bbpa_pkg.sv
src/bbpa_req_if.sv
src/bbpa_rsp_if.sv
src/bbpa_cfg_if.sv
src/bbpa_map_ram.sv
src/bbpa_div.sv
src/bitmap_block_pool_allocator.sv
verif/bitmap_block_pool_allocator_tb.sv
